FILE: rtl/page_bitmap_allocator_assert.svh
// Assertion macros for the page bitmap allocator.
// Included by the top level, which checks its own logic; define ASSERT_OFF to drop them.
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define PBA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PBA_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define PBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/pba_pkg.sv
// Package of the page bitmap allocator: sizes, codes, shared types and helpers.
// No dependencies; the row unit and the top level import it, the interfaces use its widths.
`default_nettype none

package pba_pkg;

   localparam int PAGE_TOTAL = 4096;
   localparam int PAGE_W     = $clog2(PAGE_TOTAL);
   localparam int CNT_W      = PAGE_W + 1;
   localparam int WORD_W     = 64;
   localparam int OFF_W      = $clog2(WORD_W);
   localparam int NUM_ROWS   = PAGE_TOTAL / WORD_W;
   localparam int ROW_W      = $clog2(NUM_ROWS);
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_PAGES = 1'b1;

   localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FREE      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOCK      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RESERVE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UNRESERVE = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_OOM   = 2'd1,
      STAT_RANGE = 2'd2
   } pba_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_DONE
   } pba_state_type;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_SET,
      OP_CLEAR
   } pba_op_type;

   // Control for one row pass of the shared row unit.
   typedef struct packed {
      pba_op_type       op;
      logic             is_first;
      logic             is_last;
      logic [OFF_W-1:0] lo_off;
      logic [OFF_W:0]   hi_off;   // 1..WORD_W
   } pba_row_ctl_type;

   typedef struct packed {
      logic              found;
      logic [OFF_W-1:0]  idx;
      logic [WORD_W-1:0] row_out;
   } pba_row_res_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return (sum > (CNT_W+1)'(PAGE_TOTAL)) ? CNT_W'(PAGE_TOTAL) : sum[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      return (b > a) ? '0 : a - b;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pba_req_if.sv
// Request channel of the page bitmap allocator: valid/ready plus one item.
// Depends on pba_pkg for field widths.
`default_nettype none

interface pba_req_if;
   logic                             valid;
   logic                             ready;
   logic [pba_pkg::MODE_W-1:0]       mode;
   logic [pba_pkg::PAGE_W-1:0]       start_page;
   logic [pba_pkg::CNT_W-1:0]        page_count;

   modport source (output valid, mode, start_page, page_count, input ready);
   modport sink   (input valid, mode, start_page, page_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/pba_rsp_if.sv
// Response channel of the page bitmap allocator: valid/ready plus one result item.
// Depends on pba_pkg for field widths.
`default_nettype none

interface pba_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pba_pkg::PAGE_W-1:0]       alloc_page;
   logic [pba_pkg::STATUS_W-1:0]     status;
   logic [pba_pkg::CNT_W-1:0]        free_pages;
   logic [pba_pkg::CNT_W-1:0]        used_pages;
   logic [pba_pkg::CNT_W-1:0]        reserved_pages;

   modport source (output valid, alloc_page, status, free_pages, used_pages, reserved_pages,
                   input ready);
   modport sink   (input valid, alloc_page, status, free_pages, used_pages, reserved_pages,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pba_row_unit.sv
// Shared row unit: builds the page mask of one bitmap row, finds the first
// clear page under it and forms the updated row. Depends on pba_pkg.
`default_nettype none

module pba_row_unit (
   input  wire pba_pkg::pba_row_ctl_type     ctl,
   input  wire logic [pba_pkg::WORD_W-1:0]   row_in,
   output pba_pkg::pba_row_res_type          res
);
   import pba_pkg::*;

   logic [OFF_W-1:0]  lo_off;
   logic [OFF_W:0]    hi_off;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] cand;
   logic [WORD_W-1:0] lowest;
   logic [OFF_W-1:0]  idx;

   always_comb begin
      lo_off = ctl.is_first ? ctl.lo_off : '0;
      hi_off = ctl.is_last ? ctl.hi_off : (OFF_W+1)'(WORD_W);
      // A shift by the full word width leaves zero, so the upper mask opens fully.
      mask   = ({WORD_W{1'b1}} << lo_off) & ~({WORD_W{1'b1}} << hi_off);
      cand   = ~row_in & mask;
      lowest = cand & (~cand + WORD_W'(1));
      idx    = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (lowest[j]) begin
            idx = idx | OFF_W'(j);
         end
      end
      res.found = |cand;
      res.idx   = idx;
      case (ctl.op)
         OP_ALLOC: res.row_out = row_in | lowest;
         OP_SET:   res.row_out = row_in | mask;
         default:  res.row_out = row_in & ~mask;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/page_bitmap_allocator.sv
// Page bitmap allocator top level: sequencer, page counters, config registers,
// bitmap RAM and row unit. Depends on pba_pkg, pba_req_if, pba_rsp_if, pba_ram,
// pba_row_unit and page_bitmap_allocator_assert.svh.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------------
//   req_ch   | in  | valid/ready        | mode, start_page, page_count
//   rsp_ch   | out | valid/ready        | alloc_page, status, free/used/reserved_pages
//   csr_*    | in  | csr_wr_en strobe   | csr_index, csr_wr_data (base_page, pool_pages)
//
// The bitmap lives in a RAM of 64 rows of 64 pages; every row visited passes a read
// state, then a check and write-back state, through the one shared row unit.
// An item goes through read and check for each row scanned by allocate or touched by
// a range, then to done; refused, empty and unknown items go straight to done.
// Reset is synchronous; one valid bit per row makes unwritten rows read as clear,
// so there is no clearing pass and the block is ready right after reset.
// The result sits in an output register; a stalled result holds the finished item
// in its done state, and the block accepts no next item while it waits.
`default_nettype none
`include "page_bitmap_allocator_assert.svh"

module page_bitmap_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pba_req_if.sink                                req_ch,
   pba_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_wr_en,
   input  wire logic [pba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pba_pkg::CNT_W-1:0]         csr_wr_data
);
   import pba_pkg::*;

   // control state
   pba_state_type       state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NUM_ROWS-1:0] row_vld_ff, row_vld_in;
   logic [CNT_W-1:0]    free_ff, free_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    rsvd_ff, rsvd_in;
   logic [PAGE_W-1:0]   base_ff;
   logic [CNT_W-1:0]    pool_ff;

   // per-item working registers
   pba_op_type          op_ff, op_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    first_row_ff, first_row_in;
   logic [ROW_W-1:0]    last_row_ff, last_row_in;
   logic [OFF_W-1:0]    lo_off_ff, lo_off_in;
   logic [OFF_W:0]      hi_off_ff, hi_off_in;
   logic [CNT_W-1:0]    amount_ff, amount_in;
   logic                apply_ff, apply_in;
   pba_status_type      status_ff, status_in;
   logic [PAGE_W-1:0]   grant_ff, grant_in;

   // result register
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   pba_status_type      rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_free_ff, rsp_free_in;
   logic [CNT_W-1:0]    rsp_used_ff, rsp_used_in;
   logic [CNT_W-1:0]    rsp_rsvd_ff, rsp_rsvd_in;

   // item decode at accept
   logic                acc_alloc;
   logic                acc_range;
   logic [CNT_W:0]      acc_end;
   logic                acc_over;
   logic [PAGE_W-1:0]   acc_lo;
   logic [CNT_W-1:0]    acc_hi;
   logic [CNT_W-1:0]    acc_hi_m1;
   logic                acc_empty;

   // RAM and row unit
   logic                ram_we;
   logic                ram_re;
   logic [WORD_W-1:0]   ram_rdata;
   logic [WORD_W-1:0]   row_data;
   pba_row_ctl_type     row_ctl;
   pba_row_res_type     row_res;

   logic                req_ready;
   logic                rsp_load;

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.alloc_page     = rsp_page_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.free_pages     = rsp_free_ff;
   assign rsp_ch.used_pages     = rsp_used_ff;
   assign rsp_ch.reserved_pages = rsp_rsvd_ff;

   // Decode the offered item: page window [acc_lo, acc_hi) and its row bounds.
   always_comb begin
      acc_alloc = (req_ch.mode == MODE_ALLOC);
      acc_range = (req_ch.mode >= MODE_FREE) && (req_ch.mode <= MODE_UNRESERVE);
      acc_lo    = acc_alloc ? base_ff : req_ch.start_page;
      acc_end   = acc_alloc ? ({2'b00, base_ff} + {1'b0, pool_ff})
                            : ({2'b00, req_ch.start_page} + {1'b0, req_ch.page_count});
      acc_over  = (acc_end > (CNT_W+1)'(PAGE_TOTAL));
      // Clip the allocate window at the end of the bitmap.
      acc_hi    = (acc_alloc && acc_over) ? CNT_W'(PAGE_TOTAL) : acc_end[CNT_W-1:0];
      acc_empty = (acc_hi <= {1'b0, acc_lo});
      acc_hi_m1 = acc_hi - CNT_W'(1);
   end

   assign row_data          = row_vld_ff[row_ff] ? ram_rdata : '0;
   assign row_ctl.op        = op_ff;
   assign row_ctl.is_first  = (row_ff == first_row_ff);
   assign row_ctl.is_last   = (row_ff == last_row_ff);
   assign row_ctl.lo_off    = lo_off_ff;
   assign row_ctl.hi_off    = hi_off_ff;

   pba_row_unit u_row_unit (
      .ctl    (row_ctl),
      .row_in (row_data),
      .res    (row_res)
   );

   pba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (row_ff),
      .wr_data (row_res.row_out),
      .rd_en   (ram_re),
      .rd_addr (row_ff),
      .rd_data (ram_rdata)
   );

   // Sequencer: next state and outputs.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      mode_in       = mode_ff;
      row_in        = row_ff;
      first_row_in  = first_row_ff;
      last_row_in   = last_row_ff;
      lo_off_in     = lo_off_ff;
      hi_off_in     = hi_off_ff;
      amount_in     = amount_ff;
      apply_in      = apply_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      row_vld_in    = row_vld_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      rsvd_in       = rsvd_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               mode_in      = req_ch.mode;
               grant_in     = '0;
               apply_in     = 1'b0;
               status_in    = STAT_OK;
               row_in       = acc_lo[PAGE_W-1 -: ROW_W];
               first_row_in = acc_lo[PAGE_W-1 -: ROW_W];
               last_row_in  = acc_hi_m1[PAGE_W-1 -: ROW_W];
               lo_off_in    = acc_lo[OFF_W-1:0];
               hi_off_in    = {1'b0, acc_hi_m1[OFF_W-1:0]} + (OFF_W+1)'(1);
               amount_in    = acc_alloc ? CNT_W'(1) : req_ch.page_count;
               state_in     = S_DONE;
               if (acc_alloc) begin
                  op_in = OP_ALLOC;
                  if (acc_empty) begin
                     status_in = STAT_OOM;
                  end else begin
                     state_in = S_READ;
                  end
               end else if (acc_range) begin
                  op_in = ((req_ch.mode == MODE_LOCK) || (req_ch.mode == MODE_RESERVE))
                          ? OP_SET : OP_CLEAR;
                  if (acc_over) begin
                     status_in = STAT_RANGE;
                  end else if (!acc_empty) begin
                     state_in = S_READ;
                  end
               end
            end
         end

         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_EVAL;
         end

         S_EVAL: begin
            ram_we = (op_ff != OP_ALLOC) || row_res.found;
            if (ram_we) begin
               row_vld_in[row_ff] = 1'b1;
            end
            if (op_ff == OP_ALLOC) begin
               if (row_res.found) begin
                  grant_in = {row_ff, row_res.idx};
                  apply_in = 1'b1;
                  state_in = S_DONE;
               end else if (row_ctl.is_last) begin
                  status_in = STAT_OOM;
                  state_in  = S_DONE;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  state_in = S_READ;
               end
            end else if (row_ctl.is_last) begin
               apply_in = 1'b1;
               state_in = S_DONE;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = S_READ;
            end
         end

         S_DONE: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (apply_ff) begin
                  case (mode_ff) inside
                     MODE_ALLOC, MODE_LOCK: begin
                        free_in = sat_sub(free_ff, amount_ff);
                        used_in = sat_add(used_ff, amount_ff);
                     end
                     MODE_FREE: begin
                        free_in = sat_add(free_ff, amount_ff);
                        used_in = sat_sub(used_ff, amount_ff);
                     end
                     MODE_RESERVE: begin
                        free_in = sat_sub(free_ff, amount_ff);
                        rsvd_in = sat_add(rsvd_ff, amount_ff);
                     end
                     MODE_UNRESERVE: begin
                        free_in = sat_add(free_ff, amount_ff);
                        rsvd_in = sat_sub(rsvd_ff, amount_ff);
                     end
                     default: begin
                        free_in = free_ff;
                     end
                  endcase
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register: load on completion, drop once taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_rsvd_in   = rsp_rsvd_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_page_in   = grant_ff;
         rsp_status_in = status_ff;
         rsp_free_in   = free_in;
         rsp_used_in   = used_in;
         rsp_rsvd_in   = rsvd_in;
      end else if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         free_ff      <= CNT_W'(PAGE_TOTAL);
         used_ff      <= '0;
         rsvd_ff      <= '0;
         base_ff      <= '0;
         pool_ff      <= CNT_W'(PAGE_TOTAL);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_vld_ff   <= row_vld_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         rsvd_ff      <= rsvd_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BASE_PAGE:  base_ff <= csr_wr_data[PAGE_W-1:0];
               CSR_POOL_PAGES: pool_ff <= csr_wr_data;
               default:        base_ff <= base_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      mode_ff       <= mode_in;
      row_ff        <= row_in;
      first_row_ff  <= first_row_in;
      last_row_ff   <= last_row_in;
      lo_off_ff     <= lo_off_in;
      hi_off_ff     <= hi_off_in;
      amount_ff     <= amount_in;
      apply_ff      <= apply_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_rsvd_ff   <= rsp_rsvd_in;
   end

   `PBA_ASSERT_ALWAYS(a_counter_bound, clock, reset,
      (free_ff <= CNT_W'(PAGE_TOTAL)) && (used_ff <= CNT_W'(PAGE_TOTAL))
      && (rsvd_ff <= CNT_W'(PAGE_TOTAL)), "page counter above page count")
   `PBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready,
      !req_ch.ready, "item accepted while busy")
   `PBA_ASSERT_IMPL(a_row_in_window, clock, reset, state_ff == S_EVAL,
      (row_ff >= first_row_ff) && (row_ff <= last_row_ff), "row pass outside page window")
   `PBA_ASSERT_IMPL(a_result_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_DONE), "result loaded outside completion")

endmodule

`default_nettype wire
